/* src/bpc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and fixed-point constants of the barometer compensation unit.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int ADC_BITS  = 10;
    localparam int COEF_BITS = 16;
    localparam int C12_BITS  = 14;
    localparam int OUT_BITS  = 12;
    localparam int CFG_ADDR_BITS = 2;

    // pipeline depth, output register included
    localparam int STAGES = 7;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_A0  = 2'd0,
        REG_B1  = 2'd1,
        REG_B2  = 2'd2,
        REG_C12 = 2'd3
    } cfg_reg_t;

    // pressure: y = floor((2080*comp + 1023*2^22) / 2^23), pres = floor((y + 800*1023) / 1023)
    localparam logic signed [49:0] P_BIAS   = 50'sd4290772992;
    localparam logic signed [26:0] Y_OFFSET = 27'sd818400;
    localparam logic signed [26:0] Y_LOW    = -27'sd818400;
    localparam logic signed [26:0] Y_HIGH   = 27'sd3371807;
    // ceil(2^32 / 1023), exact for dividends below 2^22
    localparam logic [22:0] P_RECIP = 23'd4198405;
    localparam int P_SHIFT = 32;

    // temperature: w = 3274035 - 3200*t, temp = floor(w / 1070) - 1170
    localparam logic [21:0] T_W0    = 22'd3274035;
    localparam logic [11:0] T_STEP  = 12'd3200;
    // ceil(2^33 / 1070), exact for dividends below 2^22
    localparam logic [22:0] T_RECIP = 23'd8027977;
    localparam int T_SHIFT = 33;
    localparam logic [11:0] T_BIAS  = 12'd1170;

    localparam logic [OUT_BITS-1:0] PRES_MAX = 12'd4095;
    localparam logic [OUT_BITS-1:0] PRES_MIN = 12'd0;

endpackage

`default_nettype wire

/* src/barometer_pressure_compensation_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// barometer_pressure_compensation_unit
// Applies calibration coefficients to raw pressure and temperature readings.
// ----------------------------------------------------------------------------
// throughput: one word per cycle while m_tready is high; each of the seven register
//   stages holds one word and moves as soon as the stage after it is free
// reset: clears all stage valid bits and sets the four coefficients to zero
module barometer_pressure_compensation_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // pressure_adc[9:0], temp_adc[19:10], zero fill
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // pressure_kpa_q4[11:0], temperature_c_q4[23:12]
    output logic [0:0]       m_tuser,   // pressure_clipped
    input  wire logic        cfg_we,
    input  wire logic [bpc_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [bpc_pkg::COEF_BITS-1:0]     cfg_wdata
);

    localparam int N = bpc_pkg::STAGES;

    // coefficients
    logic signed [15:0] a0_reg;
    logic signed [15:0] b1_reg;
    logic signed [15:0] b2_reg;
    logic signed [13:0] c12_reg;

    logic [N-1:0] vld_reg;
    logic [N-1:0] en;

    logic [9:0] p_in;
    logic [9:0] t_in;

    // stage 1
    logic signed [26:0] bp_reg, bp_next;
    logic signed [26:0] bt_reg, bt_next;
    logic signed [24:0] ct_reg, ct_next;
    logic [9:0]         p1_reg;
    logic [21:0]        tw_reg, tw_next;
    // stage 2
    logic signed [35:0] ctp_reg, ctp_next;
    logic signed [37:0] sum_reg, sum_next;
    logic [44:0]        tprod;
    logic [11:0]        tq_reg;
    // stage 3
    logic signed [37:0] comp_reg, comp_next;
    logic [11:0]        t3_reg, t3_next;
    // stage 4
    logic signed [49:0] x_full;
    logic signed [26:0] y_reg;
    logic [11:0]        t4_reg;
    // stage 5
    logic               clip_lo_reg, clip_lo_next;
    logic               clip_hi_reg, clip_hi_next;
    logic [21:0]        yoff_reg, yoff_next;
    logic [11:0]        t5_reg;
    // stage 6
    logic [44:0]        pprod;
    logic [11:0]        pres_reg, pres_next;
    logic               clip_reg;
    logic [11:0]        t6_reg;
    // output
    logic [11:0]        pres_out_reg;
    logic [11:0]        temp_out_reg;
    logic               clip_out_reg;

    assign p_in = s_tdata[9:0];
    assign t_in = s_tdata[19:10];

    // a stage may load when it is empty or its word moves on
    always_comb
    begin
        en[N-1] = !vld_reg[N-1] || m_tready;
        for (int i = N - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[N-1];
    assign m_tdata  = {temp_out_reg, pres_out_reg};
    assign m_tuser  = clip_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a0_reg  <= '0;
            b1_reg  <= '0;
            b2_reg  <= '0;
            c12_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (bpc_pkg::cfg_reg_t'(cfg_addr))
                bpc_pkg::REG_A0:  a0_reg  <= cfg_wdata;
                bpc_pkg::REG_B1:  b1_reg  <= cfg_wdata;
                bpc_pkg::REG_B2:  b2_reg  <= cfg_wdata;
                bpc_pkg::REG_C12: c12_reg <= cfg_wdata[bpc_pkg::C12_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < N; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage 1: first products and the temperature dividend
    always_comb
    begin
        bp_next = 27'(b1_reg) * 27'($signed({1'b0, p_in}));
        bt_next = 27'(b2_reg) * 27'($signed({1'b0, t_in}));
        ct_next = 25'(c12_reg) * 25'($signed({1'b0, t_in}));
        tw_next = bpc_pkg::T_W0 - 22'(22'(t_in) * 22'(bpc_pkg::T_STEP));
    end

    // stage 2: c12*t*p, partial sum at 22 fraction bits, temperature reciprocal
    always_comb
    begin
        ctp_next = 36'(ct_reg) * 36'($signed({1'b0, p1_reg}));
        sum_next = (38'(a0_reg) <<< 19) + (38'(bp_reg) <<< 9) + (38'(bt_reg) <<< 8);
        tprod    = 45'(tw_reg) * 45'(bpc_pkg::T_RECIP);
    end

    // stage 3: full compensated value and the temperature bias
    always_comb
    begin
        comp_next = sum_reg + 38'(ctp_reg);
        // always inside the output range
        t3_next   = tq_reg - bpc_pkg::T_BIAS;
    end

    // stage 4: scale by 2080 and drop 23 bits
    assign x_full = (50'(comp_reg) <<< 11) + (50'(comp_reg) <<< 5) + bpc_pkg::P_BIAS;

    // stage 5: range check and offset into the unsigned dividend
    always_comb
    begin
        clip_lo_next = y_reg < bpc_pkg::Y_LOW;
        clip_hi_next = y_reg > bpc_pkg::Y_HIGH;
        yoff_next    = 22'(y_reg + bpc_pkg::Y_OFFSET);
    end

    // stage 6: divide by 1023 through the reciprocal, then saturate
    always_comb
    begin
        pprod = 45'(yoff_reg) * 45'(bpc_pkg::P_RECIP);
        if (clip_lo_reg)
        begin
            pres_next = bpc_pkg::PRES_MIN;
        end
        else if (clip_hi_reg)
        begin
            pres_next = bpc_pkg::PRES_MAX;
        end
        else
        begin
            pres_next = pprod[bpc_pkg::P_SHIFT+11:bpc_pkg::P_SHIFT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            bp_reg <= bp_next;
            bt_reg <= bt_next;
            ct_reg <= ct_next;
            p1_reg <= p_in;
            tw_reg <= tw_next;
        end
        if (en[1])
        begin
            ctp_reg <= ctp_next;
            sum_reg <= sum_next;
            tq_reg  <= tprod[bpc_pkg::T_SHIFT+11:bpc_pkg::T_SHIFT];
        end
        if (en[2])
        begin
            comp_reg <= comp_next;
            t3_reg   <= t3_next;
        end
        if (en[3])
        begin
            y_reg  <= x_full[49:23];
            t4_reg <= t3_reg;
        end
        if (en[4])
        begin
            clip_lo_reg <= clip_lo_next;
            clip_hi_reg <= clip_hi_next;
            yoff_reg    <= yoff_next;
            t5_reg      <= t4_reg;
        end
        if (en[5])
        begin
            pres_reg <= pres_next;
            clip_reg <= clip_lo_reg || clip_hi_reg;
            t6_reg   <= t5_reg;
        end
        if (en[6])
        begin
            pres_out_reg <= pres_reg;
            clip_out_reg <= clip_reg;
            temp_out_reg <= t6_reg;
        end
    end

    // a clipped pressure word sits at one of the rails
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[11:0] == bpc_pkg::PRES_MIN)
                                   || (m_tdata[11:0] == bpc_pkg::PRES_MAX))
        else $error("clipped pressure not at a rail");

    // temperature never leaves the span reachable from a 10-bit reading
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[23:12]) >= -12'sd1170)
                     && ($signed(m_tdata[23:12]) <= 12'sd1889))
        else $error("temperature outside reachable span");

    // an empty pipeline never refuses a word
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg == '0 |-> s_tready)
        else $error("empty pipeline not ready");

    // an accepted word occupies the first stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted word lost at first stage");

    // a stalled output stage keeps everything behind a full pipeline stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg == '1) && !m_tready |-> !s_tready)
        else $error("full pipeline accepted while stalled");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// barometer compensation unit testbench
// Streams raw pressure/temperature reading pairs through the unit under
// several coefficient sets, predicts each compensated word and compares field
// by field.
// ----------------------------------------------------------------------------
module testbench;
    import bpc_pkg::*;

    localparam longint ONE_Q4       = 16;
    localparam longint GAIN_KPA     = 65;
    localparam longint BASE_KPA     = 50;
    localparam longint T_ZERO_CNT   = 498;
    localparam longint T_SLOPE_X100 = 535;
    localparam longint T_BASE_C     = 25;
    localparam longint T_SAT_LO     = -2048;
    localparam longint T_SAT_HI     = 2047;

    typedef struct packed {
        logic [OUT_BITS-1:0] pressure_q4;
        logic [OUT_BITS-1:0] temperature_q4;
        logic                clipped;
    } comp_result_t;

    class compensation_checker;
        longint a0 = 0;
        longint b1 = 0;
        longint b2 = 0;
        longint c12 = 0;
        comp_result_t predicted_q[$];
        int n_readings = 0;
        int n_checked = 0;
        int n_clipped = 0;
        int n_errors = 0;

        function void set_coeff(cfg_reg_t idx, logic [COEF_BITS-1:0] value);
            logic signed [C12_BITS-1:0] c12_bits;
            c12_bits = value[C12_BITS-1:0];
            case (idx)
                REG_A0:  a0 = $signed(value);
                REG_B1:  b1 = $signed(value);
                REG_B2:  b2 = $signed(value);
                REG_C12: c12 = c12_bits;
            endcase
        endfunction

        function longint floor_quot(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && n < 0)
                q = q - 1;
            return q;
        endfunction

        // nearest, ties go up
        function longint round_quot(longint n, longint d);
            return floor_quot(2 * n + d, 2 * d);
        endfunction

        function comp_result_t compensate(logic [ADC_BITS-1:0] p_raw,
                                          logic [ADC_BITS-1:0] t_raw);
            longint p, t, comp, den, num, pres, temp;
            comp_result_t r;
            p = p_raw;
            t = t_raw;
            // everything aligned to 22 fraction bits
            comp = a0 * 524288 + b1 * 512 * p + c12 * t * p + b2 * 256 * t;
            den = 64'sd4194304 * 1023;
            num = comp * GAIN_KPA * ONE_Q4 + BASE_KPA * ONE_Q4 * den;
            pres = round_quot(num, den);
            r.clipped = (pres < 0) || (pres > longint'(PRES_MAX));
            if (pres < 0)
                pres = 0;
            else if (pres > longint'(PRES_MAX))
                pres = PRES_MAX;
            num = (T_ZERO_CNT - t) * 100 * ONE_Q4 + T_BASE_C * ONE_Q4 * T_SLOPE_X100;
            temp = round_quot(num, T_SLOPE_X100);
            if (temp < T_SAT_LO)
                temp = T_SAT_LO;
            else if (temp > T_SAT_HI)
                temp = T_SAT_HI;
            r.pressure_q4 = pres[OUT_BITS-1:0];
            r.temperature_q4 = temp[OUT_BITS-1:0];
            return r;
        endfunction

        function void note_reading(logic [ADC_BITS-1:0] p, logic [ADC_BITS-1:0] t);
            predicted_q.push_back(compensate(p, t));
            n_readings++;
        endfunction

        task report_mismatch(string msg);
            n_errors++;
            if (n_errors <= 20)
                $display("mismatch: %s", msg);
        endtask

        task check_result(logic [23:0] data, logic flag);
            comp_result_t want;
            if (predicted_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h clip %b", data, flag));
                return;
            end
            want = predicted_q.pop_front();
            n_checked++;
            if (flag)
                n_clipped++;
            if (data[11:0] !== want.pressure_q4)
                report_mismatch($sformatf("word %0d pressure %h, want %h",
                                          n_checked, data[11:0], want.pressure_q4));
            if (data[23:12] !== want.temperature_q4)
                report_mismatch($sformatf("word %0d temperature %h, want %h",
                                          n_checked, data[23:12], want.temperature_q4));
            if (flag !== want.clipped)
                report_mismatch($sformatf("word %0d clip flag %b, want %b",
                                          n_checked, flag, want.clipped));
        endtask
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [23:0]              s_tdata;   // pressure_adc[9:0], temp_adc[19:10], zero fill
    logic                     m_tvalid;
    logic                     m_tready;
    logic [23:0]              m_tdata;   // pressure_kpa_q4[11:0], temperature_c_q4[23:12]
    logic [0:0]               m_tuser;   // pressure_clipped
    logic                     cfg_we;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [COEF_BITS-1:0]     cfg_wdata;

    compensation_checker comp_check = new;
    bit idle_enable = 1'b1;
    int sink_hold = 0;
    int n_sets = 0;

    barometer_pressure_compensation_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // receiver stalls in random bursts
    always @(posedge clk)
    begin
        if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
            m_tready <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            sink_hold = $urandom_range(1, 12) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            comp_check.check_result(m_tdata, m_tuser[0]);
    end

    function automatic logic [ADC_BITS-1:0] rand_adc();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? '1 : '0;
        return ADC_BITS'($urandom_range(0, 1023));
    endfunction

    function automatic logic [COEF_BITS-1:0] edge_coeff();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return COEF_BITS'($urandom);
        endcase
    endfunction

    task send_reading(input logic [ADC_BITS-1:0] p, input logic [ADC_BITS-1:0] t);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, t, p};
        do
            @(posedge clk);
        while (!s_tready);
        comp_check.note_reading(p, t);
    endtask

    // hold off the sender until every predicted word has come back
    task drain();
        s_tvalid <= 1'b0;
        while (comp_check.predicted_q.size() != 0)
            @(posedge clk);
    endtask

    task load_coeffs(input logic [COEF_BITS-1:0] a0, input logic [COEF_BITS-1:0] b1,
                     input logic [COEF_BITS-1:0] b2, input logic [COEF_BITS-1:0] c12);
        cfg_reg_t             regs[4];
        logic [COEF_BITS-1:0] vals[4];
        regs = '{REG_A0, REG_B1, REG_B2, REG_C12};
        vals = '{a0, b1, b2, c12};
        cfg_we <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            cfg_addr  <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
            comp_check.set_coeff(regs[i], vals[i]);
        end
        cfg_we <= 1'b0;
        n_sets++;
    endtask

    initial
    begin
        logic [COEF_BITS-1:0] ca, cb, cc, cd;
        int mode;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_A0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // coefficients still at reset: pressure sits on the 50 kPa base
        send_reading(10'd0, 10'd0);
        send_reading(10'd1023, 10'd1023);
        send_reading(10'd0, 10'd1023);
        send_reading(10'd1023, 10'd0);
        send_reading(10'd512, 10'd498);
        send_reading(10'd341, 10'd682);
        drain();

        // typical calibration
        load_coeffs(16'd16078, -16'sd19463, -16'sd15081, 16'd3314);
        send_reading(10'd0, 10'd0);
        send_reading(10'd1023, 10'd1023);
        send_reading(10'd0, 10'd1023);
        send_reading(10'd1023, 10'd0);
        send_reading(10'd600, 10'd498);
        send_reading(10'd400, 10'd520);
        drain();

        // all coefficients at the top, c12 written with junk above its width
        load_coeffs(16'h7fff, 16'h7fff, 16'h7fff, 16'hdfff);
        send_reading(10'd0, 10'd0);
        send_reading(10'd1023, 10'd1023);
        send_reading(10'd1023, 10'd0);
        send_reading(10'd0, 10'd1023);
        drain();

        // all coefficients at the bottom
        load_coeffs(16'h8000, 16'h8000, 16'h8000, 16'he000);
        send_reading(10'd0, 10'd0);
        send_reading(10'd1023, 10'd1023);
        send_reading(10'd1023, 10'd0);
        send_reading(10'd0, 10'd1023);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 9) begin
                idle_enable = 1'b0;
                mode = 0;
            end else begin
                mode = $urandom_range(0, 3);
            end
            case (mode)
                0: begin
                    ca = 16'(16078 + $urandom_range(0, 4000) - 2000);
                    cb = 16'(-19463 + $urandom_range(0, 8000) - 4000);
                    cc = 16'(-15081 + $urandom_range(0, 8000) - 4000);
                    cd = 16'(3314 + $urandom_range(0, 4000) - 2000);
                end
                1: begin
                    ca = COEF_BITS'($urandom);
                    cb = COEF_BITS'($urandom);
                    cc = COEF_BITS'($urandom);
                    cd = COEF_BITS'($urandom);
                end
                2: begin
                    ca = edge_coeff();
                    cb = edge_coeff();
                    cc = edge_coeff();
                    cd = edge_coeff();
                end
                default: begin
                    // small values keep pressure near the base, inside range
                    ca = 16'($urandom_range(0, 512)) - 16'd256;
                    cb = 16'($urandom_range(0, 512)) - 16'd256;
                    cc = 16'($urandom_range(0, 512)) - 16'd256;
                    cd = 16'($urandom_range(0, 512)) - 16'd256;
                end
            endcase
            load_coeffs(ca, cb, cc, cd);
            for (int k = 0; k < 100; k++)
                send_reading(rand_adc(), rand_adc());
            drain();
        end

        repeat (STAGES + 8) @(posedge clk);
        if (comp_check.predicted_q.size() != 0)
            comp_check.report_mismatch($sformatf("%0d words never arrived",
                                                 comp_check.predicted_q.size()));

        $display("covered %0d readings under %0d coefficient sets, %0d words saturated",
                 comp_check.n_readings, n_sets, comp_check.n_clipped);
        $display("corner readings first, then random pairs with stalls on both sides");
        if (comp_check.n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
